// ===== hdl/tkh_pkg.sv =====
// ----------------------------------------------------------------------------
// tkh_pkg
// shared types and constants of the top-k by count heap
// ----------------------------------------------------------------------------
package tkh_pkg;

	localparam int ID_W  = 31;
	localparam int CNT_W = 31;
	localparam int K_W   = 6;

	localparam logic [K_W-1:0] K_RESET = 6'd32;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DRAIN  = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [CNT_W-1:0] cnt;
	} rec_t;

	typedef struct packed {
		logic cmd;
		rec_t rec;
	} req_t;

	typedef struct packed {
		rec_t rec;
		logic last;
		logic empty;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TRIM,
		ST_POP_LD,
		ST_DN_L,
		ST_DN_R,
		ST_DN_CMP,
		ST_UP,
		ST_UP_CMP,
		ST_ROOT_CMP,
		ST_DR_RD,
		ST_DR_EMIT,
		ST_EMPTY
	} state_t;

endpackage

// ===== hdl/tkh_in_if.sv =====
// ----------------------------------------------------------------------------
// tkh_in_if
// request channel: insert or drain command with one record
// ----------------------------------------------------------------------------
interface tkh_in_if;
	logic                       valid;
	logic                       ready;
	logic                       cmd;
	logic [tkh_pkg::ID_W-1:0]   user_id;
	logic [tkh_pkg::CNT_W-1:0]  visits;

	modport source (output valid, output cmd, output user_id, output visits, input ready);
	modport sink (input valid, input cmd, input user_id, input visits, output ready);
endinterface

// ===== hdl/tkh_out_if.sv =====
// ----------------------------------------------------------------------------
// tkh_out_if
// result channel: one emitted record with last and empty flags
// ----------------------------------------------------------------------------
interface tkh_out_if;
	logic                       valid;
	logic                       ready;
	logic [tkh_pkg::ID_W-1:0]   out_id;
	logic [tkh_pkg::CNT_W-1:0]  out_visits;
	logic                       last;
	logic                       empty_res;

	modport source (output valid, output out_id, output out_visits, output last,
		output empty_res, input ready);
	modport sink (input valid, input out_id, input out_visits, input last,
		input empty_res, output ready);
endinterface

// ===== hdl/tkh_cfg_if.sv =====
// ----------------------------------------------------------------------------
// tkh_cfg_if
// configuration write channel for k_in_use
// ----------------------------------------------------------------------------
interface tkh_cfg_if;
	logic                     valid;
	logic                     ready;
	logic [tkh_pkg::K_W-1:0]  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/tkh_heap.sv =====
// ----------------------------------------------------------------------------
// tkh_heap
// bounded min-heap in a one-read one-write memory, sifted by a small sequencer
// ----------------------------------------------------------------------------
module tkh_heap #(
	parameter int MAX_K = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  tkh_pkg::req_t                req,
	input  logic [$clog2(MAX_K+1)-1:0]   k_eff,
	output logic                         res_valid,
	input  logic                         res_ready,
	output tkh_pkg::res_t                res
);

	localparam int FW = $clog2(MAX_K + 1);
	localparam int IW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int CW = IW + 2;

	tkh_pkg::rec_t mem [MAX_K];
	tkh_pkg::rec_t rd_q;

	tkh_pkg::state_t state_q, state_d;
	logic [FW-1:0]   fill_q, fill_d;
	logic [FW-1:0]   k_q, k_d;
	logic [IW-1:0]   pos_q, pos_d;
	logic            drain_q, drain_d;
	logic            final_q, final_d;
	logic            rvalid_q, rvalid_d;
	tkh_pkg::rec_t   cur_q, cur_d;
	tkh_pkg::rec_t   new_q, new_d;
	tkh_pkg::rec_t   lc_q, lc_d;

	logic            rd_en;
	logic [IW-1:0]   rd_addr;
	logic            wr_en;
	logic [IW-1:0]   wr_addr;
	tkh_pkg::rec_t   wr_data;

	logic [FW-1:0]   fill_m1;
	logic [IW-1:0]   pos_m1;
	logic [IW-1:0]   par_idx;
	logic [CW-1:0]   l_idx;
	logic [CW-1:0]   r_idx;
	logic            l_in;
	logic            r_in;
	logic            sel_l;
	logic            sel_r;
	logic [tkh_pkg::CNT_W-1:0] best_cnt;
	tkh_pkg::state_t done_st;

	always_comb begin
		fill_m1  = fill_q - FW'(1);
		pos_m1   = pos_q - IW'(1);
		par_idx  = pos_m1 >> 1;
		l_idx    = {1'b0, pos_q, 1'b1};
		r_idx    = l_idx + CW'(1);
		l_in     = l_idx < CW'(fill_q);
		r_in     = r_idx < CW'(fill_q);
		sel_l    = lc_q.cnt < cur_q.cnt;
		best_cnt = sel_l ? lc_q.cnt : cur_q.cnt;
		sel_r    = rvalid_q && (rd_q.cnt < best_cnt);
		done_st  = drain_q ? tkh_pkg::ST_DR_RD
			: (final_q ? tkh_pkg::ST_IDLE : tkh_pkg::ST_TRIM);
	end

	// memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tkh_pkg::ST_IDLE;
			fill_q   <= '0;
			drain_q  <= 1'b0;
			final_q  <= 1'b0;
			rvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			drain_q  <= drain_d;
			final_q  <= final_d;
			rvalid_q <= rvalid_d;
		end
	end

	always_ff @(posedge clk) begin
		k_q   <= k_d;
		pos_q <= pos_d;
		cur_q <= cur_d;
		new_q <= new_d;
		lc_q  <= lc_d;
	end

	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		k_d       = k_q;
		pos_d     = pos_q;
		drain_d   = drain_q;
		final_d   = final_q;
		rvalid_d  = rvalid_q;
		cur_d     = cur_q;
		new_d     = new_q;
		lc_d      = lc_q;
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = pos_q;
		wr_data   = cur_q;
		req_ready = 1'b0;
		res_valid = 1'b0;
		res.rec   = rd_q;
		res.last  = (fill_q == FW'(1));
		res.empty = 1'b0;

		case (state_q)
			tkh_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					new_d   = req.rec;
					k_d     = k_eff;
					drain_d = (req.cmd == tkh_pkg::CMD_DRAIN);
					final_d = 1'b0;
					if (req.cmd == tkh_pkg::CMD_DRAIN) begin
						state_d = (fill_q == '0) ? tkh_pkg::ST_EMPTY : tkh_pkg::ST_DR_RD;
					end else begin
						state_d = tkh_pkg::ST_TRIM;
					end
				end
			end
			tkh_pkg::ST_TRIM: begin
				if (fill_q > k_q) begin
					fill_d  = fill_m1;
					rd_en   = 1'b1;
					rd_addr = fill_m1[IW-1:0];
					state_d = tkh_pkg::ST_POP_LD;
				end else if (fill_q < k_q) begin
					pos_d   = fill_q[IW-1:0];
					fill_d  = fill_q + FW'(1);
					cur_d   = new_q;
					state_d = tkh_pkg::ST_UP;
				end else begin
					rd_en   = 1'b1;
					rd_addr = '0;
					state_d = tkh_pkg::ST_ROOT_CMP;
				end
			end
			tkh_pkg::ST_ROOT_CMP: begin
				if (new_q.cnt > rd_q.cnt) begin
					cur_d   = new_q;
					pos_d   = '0;
					final_d = 1'b1;
					state_d = tkh_pkg::ST_DN_L;
				end else begin
					state_d = tkh_pkg::ST_IDLE;
				end
			end
			tkh_pkg::ST_POP_LD: begin
				cur_d   = rd_q;
				pos_d   = '0;
				state_d = tkh_pkg::ST_DN_L;
			end
			tkh_pkg::ST_DN_L: begin
				if (l_in) begin
					rd_en   = 1'b1;
					rd_addr = l_idx[IW-1:0];
					state_d = tkh_pkg::ST_DN_R;
				end else begin
					wr_en   = 1'b1;
					state_d = done_st;
				end
			end
			tkh_pkg::ST_DN_R: begin
				lc_d     = rd_q;
				rvalid_d = r_in;
				if (r_in) begin
					rd_en   = 1'b1;
					rd_addr = r_idx[IW-1:0];
				end
				state_d = tkh_pkg::ST_DN_CMP;
			end
			tkh_pkg::ST_DN_CMP: begin
				wr_en = 1'b1;
				if (sel_r) begin
					wr_data = rd_q;
					pos_d   = r_idx[IW-1:0];
					state_d = tkh_pkg::ST_DN_L;
				end else if (sel_l) begin
					wr_data = lc_q;
					pos_d   = l_idx[IW-1:0];
					state_d = tkh_pkg::ST_DN_L;
				end else begin
					state_d = done_st;
				end
			end
			tkh_pkg::ST_UP: begin
				if (pos_q == '0) begin
					wr_en   = 1'b1;
					state_d = tkh_pkg::ST_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = par_idx;
					state_d = tkh_pkg::ST_UP_CMP;
				end
			end
			tkh_pkg::ST_UP_CMP: begin
				wr_en = 1'b1;
				if (rd_q.cnt <= cur_q.cnt) begin
					state_d = tkh_pkg::ST_IDLE;
				end else begin
					wr_data = rd_q;
					pos_d   = par_idx;
					state_d = tkh_pkg::ST_UP;
				end
			end
			tkh_pkg::ST_DR_RD: begin
				if (fill_q == '0) begin
					state_d = tkh_pkg::ST_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = '0;
					state_d = tkh_pkg::ST_DR_EMIT;
				end
			end
			tkh_pkg::ST_DR_EMIT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					fill_d  = fill_m1;
					rd_en   = 1'b1;
					rd_addr = fill_m1[IW-1:0];
					state_d = tkh_pkg::ST_POP_LD;
				end
			end
			tkh_pkg::ST_EMPTY: begin
				res_valid = 1'b1;
				res.rec   = '0;
				res.last  = 1'b1;
				res.empty = 1'b1;
				if (res_ready) begin
					state_d = tkh_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tkh_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/top_k_by_count_heap.sv =====
// ----------------------------------------------------------------------------
// top_k_by_count_heap
// keeps the k records with the highest visit counts in a bounded min-heap
// ----------------------------------------------------------------------------
// The block holds up to k records (k from k_in_use, 0 acts as 1, above MAX_K
// acts as MAX_K) in a binary min-heap stored in a one-read one-write memory.
// An insert request is stored while fewer than k records are held, otherwise
// it replaces the lowest-count record only if its count is strictly higher.
// A drain request emits every held record in ascending count order, flags the
// final one with last and empties the store; a drain of an empty store gives
// one result with empty_res and last set. Every heap level costs one memory
// read per child or parent, and the block takes no new request until the
// sequencer is back in idle. An insert into a store that is not full climbs
// the record toward the root, reading one parent per level; an insert into a
// full store that does not beat the minimum only reads the root; a replace of
// the minimum sinks the new record from the root, reading the children on
// each level; a drain emits the root, moves the last record to the root and
// sinks it, once per record, and waits while the result consumer stalls.
// Lowering k below the fill adds a pop per surplus record at the next insert;
// each pop moves the last record to the root and sinks it. The memory needs
// no clearing pass after reset.
// ----------------------------------------------------------------------------
module top_k_by_count_heap #(
	parameter int MAX_K = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	tkh_in_if.sink     item,
	tkh_out_if.source  result,
	tkh_cfg_if.sink    cfg
);

	localparam int FW  = $clog2(MAX_K + 1);
	localparam int KCW = (FW > tkh_pkg::K_W) ? FW : tkh_pkg::K_W;

	// configuration register, always writable
	logic [tkh_pkg::K_W-1:0] k_in_use_q;
	logic [FW-1:0]           k_eff;

	// heap engine handshake
	tkh_pkg::req_t eng_req;
	logic          eng_req_ready;
	logic          eng_res_valid;
	logic          eng_res_ready;
	tkh_pkg::res_t eng_res;

	// output register decouples the engine from the result consumer
	logic          out_valid_q;
	tkh_pkg::res_t out_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_in_use_q <= tkh_pkg::K_RESET;
		end else if (cfg.valid) begin
			k_in_use_q <= cfg.data;
		end
	end

	// clamp k into 1 .. MAX_K
	always_comb begin
		if (k_in_use_q == '0) begin
			k_eff = FW'(1);
		end else if (KCW'(k_in_use_q) > KCW'(MAX_K)) begin
			k_eff = FW'(MAX_K);
		end else begin
			k_eff = FW'(k_in_use_q);
		end
	end

	assign eng_req.cmd     = item.cmd;
	assign eng_req.rec.id  = item.user_id;
	assign eng_req.rec.cnt = item.visits;
	assign item.ready      = eng_req_ready;

	tkh_heap #(
		.MAX_K (MAX_K)
	) u_heap (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (item.valid),
		.req_ready (eng_req_ready),
		.req       (eng_req),
		.k_eff     (k_eff),
		.res_valid (eng_res_valid),
		.res_ready (eng_res_ready),
		.res       (eng_res)
	);

	// engine may hand over a result when the register is empty or draining
	assign eng_res_ready = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_res_valid && eng_res_ready) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_res_valid && eng_res_ready) begin
			out_q <= eng_res;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.out_id     = out_q.rec.id;
	assign result.out_visits = out_q.rec.cnt;
	assign result.last       = out_q.last;
	assign result.empty_res  = out_q.empty;

`ifndef SYNTHESIS
	// a request is taken only while the engine has no result pending
	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> !eng_res_valid)
		else $error("request accepted while a result is pending");

	// an accepted request moves the sequencer out of idle, which drops item.ready
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> !item.ready)
		else $error("engine ready right after accepting a request");

	// an empty drain result is always the final one
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.empty_res) |-> result.last)
		else $error("empty result not flagged as last");
`endif

endmodule
